@@ hw/rtl/ube_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ube_pkg
// Shared types and constants of the UBJSON token encoder.
// ----------------------------------------------------------------------------
package ube_pkg;

  localparam int NEST_DEPTH = 16;
  localparam int LEVEL_W    = $clog2(NEST_DEPTH + 1);
  localparam int ADDR_W     = $clog2(NEST_DEPTH);
  localparam int MAX_BYTES  = 13;
  localparam int LEN_W      = $clog2(MAX_BYTES + 1);

  // level flag bits
  localparam int FL_TYPE = 0;
  localparam int FL_END  = 1;
  localparam int FL_ARR  = 2;

  typedef enum logic [4:0] {
    CMD_OBJ_BEGIN = 5'd0,
    CMD_ARR_BEGIN = 5'd1,
    CMD_END       = 5'd2,
    CMD_NULL      = 5'd3,
    CMD_NOOP      = 5'd4,
    CMD_BOOL      = 5'd5,
    CMD_I8        = 5'd6,
    CMD_U8        = 5'd7,
    CMD_I16       = 5'd8,
    CMD_I32       = 5'd9,
    CMD_I64       = 5'd10,
    CMD_F32       = 5'd11,
    CMD_F64       = 5'd12,
    CMD_CHAR      = 5'd13,
    CMD_SHORT_INT = 5'd14,
    CMD_RAW       = 5'd15,
    CMD_STR_HDR   = 5'd16
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [63:0] value;
    logic [7:0]         elem_type;
    logic [2:0]         flags;
    logic               err;
  } tok_t;

  localparam logic [7:0] MK_OBJ_OPEN  = 8'h7B;
  localparam logic [7:0] MK_OBJ_CLOSE = 8'h7D;
  localparam logic [7:0] MK_ARR_OPEN  = 8'h5B;
  localparam logic [7:0] MK_ARR_CLOSE = 8'h5D;
  localparam logic [7:0] MK_TYPE      = 8'h24;
  localparam logic [7:0] MK_COUNT     = 8'h23;
  localparam logic [7:0] MK_NULL      = 8'h5A;
  localparam logic [7:0] MK_NOOP      = 8'h4E;
  localparam logic [7:0] MK_TRUE      = 8'h54;
  localparam logic [7:0] MK_FALSE     = 8'h46;
  localparam logic [7:0] MK_I8        = 8'h69;
  localparam logic [7:0] MK_U8        = 8'h55;
  localparam logic [7:0] MK_I16       = 8'h49;
  localparam logic [7:0] MK_I32       = 8'h6C;
  localparam logic [7:0] MK_I64       = 8'h4C;
  localparam logic [7:0] MK_F32       = 8'h64;
  localparam logic [7:0] MK_F64       = 8'h44;
  localparam logic [7:0] MK_CHAR      = 8'h43;
  localparam logic [7:0] MK_STR       = 8'h53;

endpackage

@@ hw/rtl/ube_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ube_if
// Channels of the encoder: token requests in, encoded bytes out.
// ----------------------------------------------------------------------------
interface ube_tok_if;
  logic               valid;
  logic               ready;
  logic [4:0]         cmd;
  logic signed [63:0] value;
  logic [7:0]         elem_type;

  modport source (output valid, cmd, value, elem_type, input ready);
  modport sink (input valid, cmd, value, elem_type, output ready);
endinterface

interface ube_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink (input valid, out_byte, last, error, output ready);
endinterface

@@ hw/rtl/ube_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ube_stack
// Nesting level and per-level flag memory; registers one token with the
// flags of its enclosing level.
// ----------------------------------------------------------------------------
module ube_stack (
  input  logic          clk,
  input  logic          rst,
  ube_tok_if.sink       tok,
  output ube_pkg::tok_t item,
  output logic          item_valid,
  input  logic          item_ready
);
  import ube_pkg::*;

  logic [2:0]         flag_mem [NEST_DEPTH];
  logic [2:0]         rd_flags;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] level_next;
  logic [ADDR_W-1:0]  rd_addr;
  logic               accept;
  cmd_t               cmd_in;
  logic               is_begin;
  logic               is_end;
  logic               ovf;
  logic               und;
  logic [2:0]         new_flags;

  cmd_t               s_cmd;
  logic signed [63:0] s_value;
  logic [7:0]         s_elem_type;
  logic               s_root;
  logic               s_err;

  assign cmd_in    = cmd_t'(tok.cmd);
  assign tok.ready = !item_valid || item_ready;
  assign accept    = tok.valid && tok.ready;
  assign is_begin  = (cmd_in == CMD_OBJ_BEGIN) || (cmd_in == CMD_ARR_BEGIN);
  assign is_end    = (cmd_in == CMD_END);
  assign ovf       = is_begin && (level == LEVEL_W'(NEST_DEPTH));
  assign und       = is_end && (level == '0);
  assign rd_addr   = ADDR_W'(level - LEVEL_W'(1));

  always_comb begin
    new_flags         = '0;
    new_flags[FL_ARR] = (cmd_in == CMD_ARR_BEGIN);
    if (tok.value[63]) begin
      new_flags[FL_TYPE] = 1'b1;
      new_flags[FL_END]  = 1'b1;
    end else begin
      new_flags[FL_TYPE] = (tok.elem_type == 8'd0);
    end
  end

  always_comb begin
    level_next = level;
    if (accept && is_begin && !ovf) begin
      level_next = level + LEVEL_W'(1);
    end else if (accept && is_end && !und) begin
      level_next = level - LEVEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_begin && !ovf) begin
      flag_mem[level[ADDR_W-1:0]] <= new_flags;
    end
    if (accept) begin
      rd_flags <= flag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= '0;
      item_valid <= 1'b0;
    end else begin
      level <= level_next;
      if (accept) begin
        item_valid <= 1'b1;
      end else if (item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_cmd       <= cmd_in;
      s_value     <= tok.value;
      s_elem_type <= tok.elem_type;
      s_root      <= (level == '0);
      s_err       <= ovf || und;
    end
  end

  // root level writes type markers
  assign item.cmd       = s_cmd;
  assign item.value     = s_value;
  assign item.elem_type = s_elem_type;
  assign item.flags     = s_root ? 3'(1 << FL_TYPE) : rd_flags;
  assign item.err       = s_err;

endmodule

@@ hw/rtl/ube_serializer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ube_serializer
// Builds the byte run of one token and sends it one byte per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module ube_serializer (
  input  logic          clk,
  input  logic          rst,
  input  ube_pkg::tok_t item,
  input  logic          item_valid,
  output logic          item_ready,
  ube_byte_if.source    enc
);
  import ube_pkg::*;

  logic [7:0]       hdr [4];
  logic [2:0]       hlen;
  logic             mk;
  logic [7:0]       mkv;
  logic [3:0]       pn;
  logic [7:0]       sh_mk;
  logic [3:0]       sh_n;
  logic [63:0]      pay;
  logic [3:0]       off;
  logic [LEN_W-1:0] len_n;
  logic [7:0]       buf_n [MAX_BYTES];
  logic             typ;
  logic             fits8;

  logic [7:0]       buf_q [MAX_BYTES];
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] idx_q;
  logic             err_q;
  logic             busy;
  logic             out_fire;
  logic             out_last;
  logic             load;

  assign typ = item.flags[FL_TYPE];

  // shortest integer form
  always_comb begin
    fits8 = (item.value >= -64'sd128) && (item.value < 64'sd128);
    if (fits8) begin
      sh_mk = MK_I8;
      sh_n  = 4'd1;
    end else if ((item.value >= 64'sd0) && (item.value < 64'sd256)) begin
      sh_mk = MK_U8;
      sh_n  = 4'd1;
    end else if ((item.value >= -64'sd32768) && (item.value < 64'sd32768)) begin
      sh_mk = MK_I16;
      sh_n  = 4'd2;
    end else if ((item.value >= -64'sd2147483648) && (item.value < 64'sd2147483648)) begin
      sh_mk = MK_I32;
      sh_n  = 4'd4;
    end else begin
      sh_mk = MK_I64;
      sh_n  = 4'd8;
    end
  end

  always_comb begin
    hdr[0] = 8'd0;
    hdr[1] = 8'd0;
    hdr[2] = 8'd0;
    hdr[3] = 8'd0;
    hlen   = 3'd0;
    mk     = 1'b0;
    mkv    = 8'd0;
    pn     = 4'd0;
    if (item.err) begin
      hlen = 3'd1;
    end else begin
      unique case (item.cmd)
        CMD_OBJ_BEGIN, CMD_ARR_BEGIN: begin
          hdr[0] = (item.cmd == CMD_ARR_BEGIN) ? MK_ARR_OPEN : MK_OBJ_OPEN;
          hlen   = 3'd1;
          if (!item.value[63]) begin
            mk  = 1'b1;
            mkv = sh_mk;
            pn  = sh_n;
            if (item.elem_type != 8'd0) begin
              hdr[1] = MK_TYPE;
              hdr[2] = item.elem_type;
              hdr[3] = MK_COUNT;
              hlen   = 3'd4;
            end else begin
              hdr[1] = MK_COUNT;
              hlen   = 3'd2;
            end
          end
        end
        CMD_END: begin
          hdr[0] = item.flags[FL_ARR] ? MK_ARR_CLOSE : MK_OBJ_CLOSE;
          hlen   = item.flags[FL_END] ? 3'd1 : 3'd0;
        end
        CMD_NULL: begin
          mk  = typ;
          mkv = MK_NULL;
        end
        CMD_NOOP: begin
          mk  = typ;
          mkv = MK_NOOP;
        end
        CMD_BOOL: begin
          mk  = typ;
          mkv = (item.value != 64'sd0) ? MK_TRUE : MK_FALSE;
        end
        CMD_I8: begin
          mk  = typ;
          mkv = MK_I8;
          pn  = 4'd1;
        end
        CMD_U8: begin
          mk  = typ;
          mkv = MK_U8;
          pn  = 4'd1;
        end
        CMD_I16: begin
          mk  = typ;
          mkv = MK_I16;
          pn  = 4'd2;
        end
        CMD_I32: begin
          mk  = typ;
          mkv = MK_I32;
          pn  = 4'd4;
        end
        CMD_I64: begin
          mk  = typ;
          mkv = MK_I64;
          pn  = 4'd8;
        end
        CMD_F32: begin
          mk  = typ;
          mkv = MK_F32;
          pn  = 4'd4;
        end
        CMD_F64: begin
          mk  = typ;
          mkv = MK_F64;
          pn  = 4'd8;
        end
        CMD_CHAR: begin
          mk  = typ;
          mkv = MK_CHAR;
          pn  = 4'd1;
        end
        CMD_SHORT_INT: begin
          mk  = 1'b1;
          mkv = sh_mk;
          pn  = sh_n;
        end
        CMD_RAW: begin
          pn = 4'd1;
        end
        CMD_STR_HDR: begin
          hdr[0] = MK_STR;
          hlen   = typ ? 3'd1 : 3'd0;
          mk     = 1'b1;
          mkv    = sh_mk;
          pn     = sh_n;
        end
        default: begin
        end
      endcase
    end
  end

  // payload left-aligned, most significant byte first
  always_comb begin
    unique case (pn)
      4'd1:    pay = {item.value[7:0], 56'd0};
      4'd2:    pay = {item.value[15:0], 48'd0};
      4'd4:    pay = {item.value[31:0], 32'd0};
      default: pay = item.value;
    endcase
  end

  assign off   = {1'b0, hlen} + {3'd0, mk};
  assign len_n = LEN_W'(off + pn);

  always_comb begin
    for (int i = 0; i < MAX_BYTES; i++) begin
      if (4'(i) < {1'b0, hlen}) begin
        buf_n[i] = hdr[i % 4];
      end else if (mk && (4'(i) == {1'b0, hlen})) begin
        buf_n[i] = mkv;
      end else if ((4'(i) >= off) && ((4'(i) - off) < 4'd8)) begin
        buf_n[i] = pay[(7 - ((4'(i) - off) & 4'd7)) * 8 +: 8];
      end else begin
        buf_n[i] = 8'd0;
      end
    end
  end

  assign out_last   = (idx_q == len_q - LEN_W'(1));
  assign out_fire   = enc.valid && enc.ready;
  assign item_ready = !busy || (out_fire && out_last);
  assign load       = item_valid && item_ready && (len_n != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        busy  <= 1'b1;
        idx_q <= '0;
      end else if (out_fire) begin
        busy  <= !out_last;
        idx_q <= idx_q + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_q <= buf_n;
      len_q <= len_n;
      err_q <= item.err;
    end
  end

  assign enc.valid    = busy;
  assign enc.out_byte = buf_q[idx_q];
  assign enc.last     = out_last;
  assign enc.error    = err_q;

endmodule

@@ hw/rtl/ubjson_token_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubjson_token_encoder
// Encodes one serialization token per request into UBJSON bytes.
// ----------------------------------------------------------------------------
// A token that produces n bytes sends them one byte per cycle while the byte
// sink is ready; tokens that produce no bytes pass at one per cycle while no
// run is being sent. The byte sink sets the rate, and the next token is taken
// while the current run is still being sent. Between taking a token and its
// first byte lie the stack register, which reads the enclosing level's flags,
// and the byte buffer into which the run is built. The flag memory is not
// cleared after reset; only entries pushed by a container start are used.
module ubjson_token_encoder (
  input logic         clk,
  input logic         rst,
  ube_tok_if.sink     tok,
  ube_byte_if.source  enc
);
  import ube_pkg::*;

  tok_t item;
  logic item_valid;
  logic item_ready;

  ube_stack u_stack (
    .clk        (clk),
    .rst        (rst),
    .tok        (tok),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  ube_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .enc        (enc)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives token requests into the UBJSON token encoder and checks every encoded
// byte, with its last and error marks, against a byte-exact predictor that
// tracks the nesting stack. A short table of directed tokens comes first, then
// random documents with key runs, deep dives to the nesting limit and noise.
// Both sides idle in random bursts, the byte sink holds off once for a long
// stretch and the token source once drains the block before going on.
// ----------------------------------------------------------------------------
module testbench;
  import ube_pkg::*;

  localparam int         TOKENS          = 412;
  localparam int         CALM_TAIL       = 40;
  localparam int         HOLD_CYCLES     = 200;
  localparam logic [4:0] CMD_NOT_DEFINED = 5'd31;
  localparam longint     LIM32           = 64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [4:0]         cmd;
    logic signed [63:0] value;
    logic [7:0]         elem_type;
    logic               given;
    logic [3:0]         n;
    logic [103:0]       bytes;
    logic               err;
  } token_row_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } enc_beat_t;

  logic clk;
  logic rst;

  ube_tok_if  tok();
  ube_byte_if enc();

  ubjson_token_encoder i_dut (
    .clk (clk),
    .rst (rst),
    .tok (tok),
    .enc (enc)
  );

  token_row_t plan[$];
  token_row_t cur_row;
  enc_beat_t  enc_expect[$];
  logic [7:0] run_q[$];
  logic       run_err;
  logic [2:0] lvl_flags [NEST_DEPTH];
  int         exp_lvl;
  int         deepest;
  int         fails;
  int         bytes_checked;
  int         err_results;
  int         counted;
  int         gap_pct;
  int         stall_pct;
  bit         calm;
  bit         hold_req;
  bit         hold_done;
  bit         dive;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int idle_mix();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  // appends one byte to the predicted run
  function automatic void add_byte(logic [7:0] b);
    run_q.insert(run_q.size(), b);
  endfunction

  // appends one expected output beat
  function automatic void add_beat(logic [7:0] ob, logic lst, logic er);
    enc_beat_t b;
    b.out_byte = ob;
    b.last     = lst;
    b.error    = er;
    enc_expect.insert(enc_expect.size(), b);
  endfunction

  function automatic void put_be(logic [63:0] u, int n);
    for (int i = n - 1; i >= 0; i--) add_byte(u[8*i +: 8]);
  endfunction

  function automatic void put_shortest(longint v);
    if (v >= -128 && v < 128) begin
      add_byte(MK_I8);
      put_be(v, 1);
    end else if (v >= 0 && v < 256) begin
      add_byte(MK_U8);
      put_be(v, 1);
    end else if (v >= -32768 && v < 32768) begin
      add_byte(MK_I16);
      put_be(v, 2);
    end else if (v >= -LIM32 && v < LIM32) begin
      add_byte(MK_I32);
      put_be(v, 4);
    end else begin
      add_byte(MK_I64);
      put_be(v, 8);
    end
  endfunction

  // updates the nesting stack and leaves the byte run in run_q / run_err
  function automatic void encode_token(logic [4:0] cmd, logic signed [63:0] v,
                                       logic [7:0] et);
    logic [2:0] top;
    logic [2:0] nf;
    logic       typ;
    top = '0;
    nf  = '0;
    if (exp_lvl == 0) top[FL_TYPE] = 1'b1;
    else top = lvl_flags[exp_lvl-1];
    typ = top[FL_TYPE];
    run_q.delete();
    run_err = 1'b0;
    case (cmd)
      CMD_OBJ_BEGIN, CMD_ARR_BEGIN: begin
        if (exp_lvl >= NEST_DEPTH) begin
          run_err = 1'b1;
        end else begin
          nf[FL_ARR] = (cmd == CMD_ARR_BEGIN);
          add_byte(nf[FL_ARR] ? MK_ARR_OPEN : MK_OBJ_OPEN);
          if (!v[63]) begin
            if (et != 8'h00) begin
              add_byte(MK_TYPE);
              add_byte(et);
            end else begin
              nf[FL_TYPE] = 1'b1;
            end
            add_byte(MK_COUNT);
            put_shortest(v);
          end else begin
            nf[FL_TYPE] = 1'b1;
            nf[FL_END]  = 1'b1;
          end
          lvl_flags[exp_lvl] = nf;
          exp_lvl++;
          if (exp_lvl > deepest) deepest = exp_lvl;
        end
      end
      CMD_END: begin
        if (exp_lvl == 0) begin
          run_err = 1'b1;
        end else begin
          if (top[FL_END]) add_byte(top[FL_ARR] ? MK_ARR_CLOSE : MK_OBJ_CLOSE);
          exp_lvl--;
        end
      end
      CMD_NULL: if (typ) add_byte(MK_NULL);
      CMD_NOOP: if (typ) add_byte(MK_NOOP);
      CMD_BOOL: if (typ) add_byte(v != 0 ? MK_TRUE : MK_FALSE);
      CMD_I8: begin
        if (typ) add_byte(MK_I8);
        put_be(v, 1);
      end
      CMD_U8: begin
        if (typ) add_byte(MK_U8);
        put_be(v, 1);
      end
      CMD_I16: begin
        if (typ) add_byte(MK_I16);
        put_be(v, 2);
      end
      CMD_I32: begin
        if (typ) add_byte(MK_I32);
        put_be(v, 4);
      end
      CMD_I64: begin
        if (typ) add_byte(MK_I64);
        put_be(v, 8);
      end
      CMD_F32: begin
        if (typ) add_byte(MK_F32);
        put_be(v, 4);
      end
      CMD_F64: begin
        if (typ) add_byte(MK_F64);
        put_be(v, 8);
      end
      CMD_CHAR: begin
        if (typ) add_byte(MK_CHAR);
        put_be(v, 1);
      end
      CMD_SHORT_INT: put_shortest(v);
      CMD_RAW: put_be(v, 1);
      CMD_STR_HDR: begin
        if (typ) add_byte(MK_STR);
        put_shortest(v);
      end
      default: ;
    endcase
  endfunction

  function automatic void plan_token(logic [4:0] cmd, logic signed [63:0] v,
                                     logic [7:0] et, logic given, int n,
                                     logic [103:0] bytes, logic err);
    token_row_t r;
    r.cmd       = cmd;
    r.value     = v;
    r.elem_type = et;
    r.given     = given;
    r.n         = n[3:0];
    r.bytes     = bytes;
    r.err       = err;
    plan.insert(plan.size(), r);
  endfunction

  function automatic logic signed [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return longint'($urandom_range(0, 600)) - 300;
      1: begin
        case ($urandom_range(0, 14))
          0: return -129;
          1: return -128;
          2: return 127;
          3: return 128;
          4: return 255;
          5: return 256;
          6: return -32769;
          7: return 32767;
          8: return 32768;
          9: return LIM32 - 1;
          10: return LIM32;
          11: return -LIM32;
          12: return -LIM32 - 1;
          13: return {1'b1, 63'd0};
          default: return {1'b0, {63{1'b1}}};
        endcase
      end
      2, 3: return {$urandom, $urandom};
      4: return longint'($urandom_range(0, 1));
      default: return longint'(int'($urandom));
    endcase
  endfunction

  // one well-formed step of a random document, sometimes noise or a dive
  function automatic void gen_tokens();
    logic signed [63:0] cnt;
    logic [4:0]         cmd;
    logic               in_obj;
    int                 pick;
    int                 n;
    in_obj = (exp_lvl > 0) && !lvl_flags[exp_lvl-1][FL_ARR];
    if (dive) begin
      if (exp_lvl >= NEST_DEPTH) dive = 1'b0;
      plan_token($urandom_range(0, 1) ? CMD_ARR_BEGIN : CMD_OBJ_BEGIN,
                 {1'b1, $urandom, 31'($urandom)}, 8'($urandom), 1'b0, 0, '0, 1'b0);
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      plan_token(5'($urandom_range(0, 31)), rand_value(), 8'($urandom),
                 1'b0, 0, '0, 1'b0);
    end else if (pick < 8 && exp_lvl == 0) begin
      dive = 1'b1;
    end else if (pick < 28 && exp_lvl < NEST_DEPTH) begin
      case ($urandom_range(0, 3))
        0: cnt = {1'b1, $urandom, 31'($urandom)};
        1: cnt = (rand_value() & 64'h7FFF_FFFF_FFFF_FFFF) >>> 1;
        default: cnt = longint'($urandom_range(0, 20));
      endcase
      plan_token($urandom_range(0, 1) ? CMD_ARR_BEGIN : CMD_OBJ_BEGIN, cnt,
                 $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255)),
                 1'b0, 0, '0, 1'b0);
    end else if (pick < 28 + 6 * exp_lvl || (exp_lvl == 0 && pick < 30)) begin
      plan_token(CMD_END, rand_value(), 8'($urandom), 1'b0, 0, '0, 1'b0);
    end else begin
      if (in_obj && $urandom_range(0, 1)) begin
        n = $urandom_range(0, 4);
        plan_token(CMD_STR_HDR, longint'(n), 8'($urandom), 1'b0, 0, '0, 1'b0);
        repeat (n) plan_token(CMD_RAW, rand_value(), 8'($urandom), 1'b0, 0, '0, 1'b0);
      end
      cmd = 5'($urandom_range(int'(CMD_NULL), int'(CMD_STR_HDR)));
      if (cmd == CMD_STR_HDR) begin
        n = $urandom_range(0, 5);
        plan_token(cmd, longint'(n), 8'($urandom), 1'b0, 0, '0, 1'b0);
        repeat (n) plan_token(CMD_RAW, rand_value(), 8'($urandom), 1'b0, 0, '0, 1'b0);
      end else begin
        plan_token(cmd, rand_value(), 8'($urandom), 1'b0, 0, '0, 1'b0);
      end
    end
  endfunction

  always @(posedge clk) begin
    enc_beat_t b;
    if (!rst) begin
      if (tok.valid && tok.ready) begin
        encode_token(tok.cmd, tok.value, tok.elem_type);
        if (cur_row.given) begin
          run_q.delete();
          for (int k = 0; k < int'(cur_row.n); k++)
            add_byte(cur_row.bytes[8*(int'(cur_row.n)-1-k) +: 8]);
          run_err = cur_row.err;
        end
        if (run_err) begin
          add_beat(8'h00, 1'b1, 1'b1);
          err_results++;
        end else begin
          for (int k = 0; k < run_q.size(); k++)
            add_beat(run_q[k], k == run_q.size() - 1, 1'b0);
        end
      end
      if (enc.valid && enc.ready) begin
        if (enc_expect.size() == 0) begin
          $display("%0t: unexpected byte %h last %b error %b", $time,
                   enc.out_byte, enc.last, enc.error);
          fails++;
        end else begin
          b = enc_expect.pop_front();
          bytes_checked++;
          if (enc.out_byte !== b.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, b.out_byte, enc.out_byte);
            fails++;
          end
          if (enc.last !== b.last) begin
            $display("%0t: last expected %b actual %b", $time, b.last, enc.last);
            fails++;
          end
          if (enc.error !== b.error) begin
            $display("%0t: error expected %b actual %b", $time, b.error, enc.error);
            fails++;
          end
        end
      end
    end
  end

  // byte sink: random stall bursts and one long hold-off
  initial begin
    int hold_left;
    int stall_left;
    int cyc;
    hold_left  = 0;
    stall_left = 0;
    cyc        = 0;
    stall_pct  = 15;
    enc.ready  = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 256 == 0) stall_pct = idle_mix();
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        enc.ready <= 1'b0;
      end else if (calm) begin
        enc.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        enc.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 14);
        enc.ready <= 1'b0;
      end else begin
        enc.ready <= 1'b1;
      end
    end
  end

  // token source
  initial begin
    token_row_t r;
    bit         paused;
    paused        = 1'b0;
    fails         = 0;
    bytes_checked = 0;
    err_results   = 0;
    counted       = 0;
    exp_lvl       = 0;
    deepest       = 0;
    gap_pct       = 15;
    calm          = 1'b0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    dive          = 1'b0;
    cur_row       = '0;
    tok.valid     = 1'b0;
    tok.cmd       = '0;
    tok.value     = '0;
    tok.elem_type = '0;
    rst           = 1'b1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    plan_token(CMD_END, 64'sd0, 8'h00, 1'b1, 0, '0, 1'b1);
    plan_token(CMD_NULL, 64'sd0, 8'h00, 1'b1, 1, {MK_NULL}, 1'b0);
    plan_token(CMD_NOOP, 64'sd0, 8'h00, 1'b1, 1, {MK_NOOP}, 1'b0);
    plan_token(CMD_BOOL, 64'sh8000_0000_0000_0000, 8'h00, 1'b1, 1, {MK_TRUE}, 1'b0);
    plan_token(CMD_BOOL, 64'sd0, 8'h00, 1'b1, 1, {MK_FALSE}, 1'b0);
    plan_token(CMD_I8, 64'sh1234_5678_9ABC_DE80, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_U8, 64'sh0000_0000_0000_00FF, 8'hFF, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_I16, -64'sd1, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_I32, 64'shFFFF_0000_8000_0000, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_I64, 64'sh8000_0000_0000_0000, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_F32, 64'sh0000_0000_3F80_0000, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_F64, 64'sh7FFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_CHAR, 64'sh0000_0000_0000_0041, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_SHORT_INT, 64'sh7FFF_FFFF_FFFF_FFFF, 8'h00, 1'b1, 9,
               {MK_I64, 64'h7FFF_FFFF_FFFF_FFFF}, 1'b0);
    plan_token(CMD_SHORT_INT, 64'sh8000_0000_0000_0000, 8'h00, 1'b1, 9,
               {MK_I64, 64'h8000_0000_0000_0000}, 1'b0);
    plan_token(CMD_RAW, 64'sh0000_0000_0000_00FF, 8'h00, 1'b1, 1, {8'hFF}, 1'b0);
    plan_token(CMD_STR_HDR, -64'sd5, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_NOT_DEFINED, -64'sd1, 8'hFF, 1'b1, 0, '0, 1'b0);
    plan_token(CMD_OBJ_BEGIN, -64'sd1, 8'h00, 1'b1, 1, {MK_OBJ_OPEN}, 1'b0);
    plan_token(CMD_ARR_BEGIN, 64'sd2, MK_U8, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_BOOL, 64'sd1, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_U8, 64'sh0000_0000_0000_0080, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_END, 64'sd0, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_END, 64'sd0, 8'h00, 1'b1, 1, {MK_OBJ_CLOSE}, 1'b0);
    plan_token(CMD_ARR_BEGIN, -64'sd7, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_ARR_BEGIN, 64'sd300, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_END, 64'sd0, 8'h00, 1'b0, 0, '0, 1'b0);
    plan_token(CMD_END, 64'sd0, 8'h00, 1'b1, 1, {MK_ARR_CLOSE}, 1'b0);

    @(negedge clk);
    while (counted < TOKENS || plan.size() != 0) begin
      while (plan.size() == 0) gen_tokens();
      r = plan.pop_front();
      calm = (counted >= TOKENS - CALM_TAIL);
      if (counted % 50 == 0) gap_pct = idle_mix();
      if (counted == 120) hold_req = 1'b1;
      if (counted >= 220 && !paused) begin
        // drain: hold new tokens until every byte is out
        paused = 1'b1;
        tok.valid <= 1'b0;
        do @(negedge clk); while (enc_expect.size() != 0);
      end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
        tok.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      cur_row = r;
      tok.valid     <= 1'b1;
      tok.cmd       <= r.cmd;
      tok.value     <= r.value;
      tok.elem_type <= r.elem_type;
      @(posedge clk);
      while (!tok.ready) @(posedge clk);
      @(negedge clk);
      if (r.cmd <= CMD_STR_HDR) counted++;
    end
    tok.valid <= 1'b0;
    do @(negedge clk); while (enc_expect.size() != 0);
    repeat (20) @(negedge clk);
    if (enc_expect.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, enc_expect.size());
      fails++;
    end
    $display("testbench: %0d token requests, %0d bytes checked, %0d nesting errors",
             counted, bytes_checked, err_results);
    $display("testbench: nesting reached %0d of %0d, %0d mismatches",
             deepest, NEST_DEPTH, fails);
    if (fails == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
